// File: design/lzte_pkg.sv
// Shared types and constants for the LZ77 token encoder.
`default_nettype none

package lzte_pkg;

  // Window cells are searched in groups of this many for the longest offset.
  localparam int GROUP_SIZE  = 16;
  localparam int GROUP_IDX_W = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic scan;
    logic start;
    logic commit;
    logic flush;
    logic close;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic                   any;
    logic [GROUP_IDX_W-1:0] idx;
  } group_hit_t;

endpackage

`default_nettype wire

// File: design/lzte_if.sv
// Handshake channels for text bytes in and tokens out.
`default_nettype none

interface lzte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lzte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] match_offset;
  logic [7:0] match_length;
  logic [7:0] next_char;
  logic       end_of_stream;

  modport source (output valid, output match_offset, output match_length,
                  output next_char, output end_of_stream, input ready);
  modport sink   (input valid, input match_offset, input match_length,
                  input next_char, input end_of_stream, output ready);
endinterface

`default_nettype wire

// File: design/lzte_cell.sv
// One window position: history byte, fill bit and match candidate bit.
`default_nettype none

module lzte_cell import lzte_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic [7:0] probe,
  input  logic [7:0] prev_byte,
  input  logic      prev_valid,
  output logic [7:0] hist,
  output logic      valid,
  output logic      alive,
  output logic      hit_now
);

  logic hit_held;

  // At the start of a token every filled position may match; later only live ones.
  assign hit_now = valid && (hist == probe) && (ctl.start || alive);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      alive <= 1'b0;
    end else if (ctl.commit) begin
      if (ctl.flush) begin
        valid <= 1'b0;
        alive <= 1'b0;
      end else begin
        valid <= prev_valid;
        if (ctl.close) begin
          alive <= 1'b0;
        end else if (ctl.load) begin
          alive <= hit_held;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      hit_held <= hit_now;
    end
    if (ctl.commit && !ctl.flush) begin
      hist <= prev_byte;
    end
  end

endmodule

`default_nettype wire

// File: design/lzte_group.sv
// Registered priority encoder that finds the highest hit in one group of cells.
`default_nettype none

module lzte_group import lzte_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [GROUP_SIZE-1:0] hits,
  output group_hit_t            result
);

  group_hit_t found;

  always_comb begin
    found.any = |hits;
    found.idx = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (hits[i]) begin
        found.idx = GROUP_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= found;
    end
  end

endmodule

`default_nettype wire

// File: design/lz77_token_encoder_top.sv
// Greedy LZ77 triple encoder: a shifting row of window cells and a grouped offset search.
// Each text byte is accepted, compared in all cells with per-group encoding, then
// passed to group select and state update; no item overlaps another.
// A token is written to the output register by the state update, which waits
// while the previous token has not been taken.
// Reset (synchronous rst) empties the window and closes any open match at once.
`default_nettype none

module lz77_token_encoder_top import lzte_pkg::*; #(
  parameter int WINDOW_SIZE = 255,
  parameter int MAX_MATCH   = 255
) (
  input  logic       clk,
  input  logic       rst,
  lzte_in_if.sink    text,
  lzte_out_if.source token
);

  localparam int NUM_GROUPS = (WINDOW_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_W      = NUM_GROUPS * GROUP_SIZE;
  localparam int SEL_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam logic [7:0] MAX_LEN = 8'(MAX_MATCH);

  state_t state, state_next;

  logic [7:0] probe;
  logic       probe_last;
  logic [7:0] cur_len, cur_len_next;
  logic [7:0] best_off, best_off_next;

  logic       tok_valid;
  logic [7:0] tok_off, tok_len, tok_chr;
  logic       tok_eos;

  cell_ctl_t  ctl;
  logic       commit, produce, slot_free, is_start, at_limit, found;
  logic [7:0] e_off, e_len, e_chr;
  logic       e_eos;
  logic [SEL_W-1:0]       sel;
  logic [GROUP_IDX_W-1:0] sel_idx;
  logic [7:0] best;

  logic [7:0]             hist [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] valid_vec, alive_vec;
  logic [PAD_W-1:0]       hit_vec;
  group_hit_t             grp [NUM_GROUPS];

  // Window cells: cell k holds the byte k+1 positions back and shifts toward k+1.
  for (genvar k = 0; k < WINDOW_SIZE; k++) begin : g_cell
    if (k == 0) begin : g_head
      lzte_cell u_cell (
        .clk, .rst, .ctl, .probe,
        .prev_byte (probe),
        .prev_valid(1'b1),
        .hist      (hist[k]),
        .valid     (valid_vec[k]),
        .alive     (alive_vec[k]),
        .hit_now   (hit_vec[k])
      );
    end else begin : g_body
      lzte_cell u_cell (
        .clk, .rst, .ctl, .probe,
        .prev_byte (hist[k-1]),
        .prev_valid(valid_vec[k-1]),
        .hist      (hist[k]),
        .valid     (valid_vec[k]),
        .alive     (alive_vec[k]),
        .hit_now   (hit_vec[k])
      );
    end
  end

  if (PAD_W > WINDOW_SIZE) begin : g_pad
    assign hit_vec[PAD_W-1:WINDOW_SIZE] = '0;
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    lzte_group u_group (
      .clk,
      .en    (ctl.scan),
      .hits  (hit_vec[g*GROUP_SIZE +: GROUP_SIZE]),
      .result(grp[g])
    );
  end

  // The highest group with a hit holds the largest matching offset.
  always_comb begin
    found   = 1'b0;
    sel     = '0;
    sel_idx = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (grp[g].any) begin
        found   = 1'b1;
        sel     = SEL_W'(g);
        sel_idx = grp[g].idx;
      end
    end
    best = 8'(9'({sel, sel_idx}) + 9'd1);
  end

  assign slot_free  = !tok_valid || token.ready;
  assign is_start   = (cur_len == 8'd0);
  assign at_limit   = (cur_len >= MAX_LEN);
  assign text.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl           = '0;
    ctl.start     = is_start;
    commit        = 1'b0;
    produce       = 1'b0;
    e_off         = 8'd0;
    e_len         = 8'd0;
    e_chr         = 8'd0;
    e_eos         = 1'b0;
    cur_len_next  = cur_len;
    best_off_next = best_off;
    unique case (state)
      ST_IDLE: begin
        if (text.valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.scan   = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (slot_free) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
          if (is_start) begin
            if (!found) begin
              produce   = 1'b1;
              e_chr     = probe;
              e_eos     = probe_last;
              ctl.close = 1'b1;
            end else begin
              ctl.load      = 1'b1;
              cur_len_next  = 8'd1;
              best_off_next = best;
              if (probe_last) begin
                produce = 1'b1;
                e_off   = best;
                e_len   = 8'd1;
                e_eos   = 1'b1;
              end
            end
          end else if (at_limit || !found) begin
            // The match closes on this byte, which becomes the next character.
            produce       = 1'b1;
            e_off         = best_off;
            e_len         = cur_len;
            e_chr         = probe;
            e_eos         = probe_last;
            ctl.close     = 1'b1;
            cur_len_next  = 8'd0;
            best_off_next = 8'd0;
          end else begin
            ctl.load      = 1'b1;
            cur_len_next  = cur_len + 8'd1;
            best_off_next = best;
            if (probe_last) begin
              produce = 1'b1;
              e_off   = best;
              e_len   = cur_len + 8'd1;
              e_eos   = 1'b1;
            end
          end
          if (probe_last) begin
            ctl.flush     = 1'b1;
            cur_len_next  = 8'd0;
            best_off_next = 8'd0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    ctl.commit = commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_len   <= 8'd0;
      best_off  <= 8'd0;
      tok_valid <= 1'b0;
    end else begin
      if (commit) begin
        cur_len  <= cur_len_next;
        best_off <= best_off_next;
      end
      if (commit && produce) begin
        tok_valid <= 1'b1;
      end else if (token.ready) begin
        tok_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      probe      <= text.data_byte;
      probe_last <= text.last_byte;
    end
    if (commit && produce) begin
      tok_off <= e_off;
      tok_len <= e_len;
      tok_chr <= e_chr;
      tok_eos <= e_eos;
    end
  end

  assign token.valid         = tok_valid;
  assign token.match_offset  = tok_off;
  assign token.match_length  = tok_len;
  assign token.next_char     = tok_chr;
  assign token.end_of_stream = tok_eos;

  a_open_has_offset: assert property (@(posedge clk) disable iff (rst)
    cur_len != 8'd0 |-> best_off != 8'd0)
    else $error("open match without an offset");

  a_idle_no_candidates: assert property (@(posedge clk) disable iff (rst)
    cur_len == 8'd0 |-> alive_vec == '0)
    else $error("live candidates while no match is open");

  a_alive_in_window: assert property (@(posedge clk) disable iff (rst)
    (alive_vec & ~valid_vec) == '0)
    else $error("candidate outside the filled window");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    cur_len <= MAX_LEN)
    else $error("match length beyond the limit");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (commit && probe_last) |=> (cur_len == 8'd0 && valid_vec == '0))
    else $error("window not emptied after the final byte");

endmodule

`default_nettype wire

// File: test/lz77_token_encoder_top_test.sv
// Self-checking testbench for the LZ77 token encoder: directed and random texts.
`default_nettype none

module lz77_token_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN        = 255;
  localparam int MAX_RUN    = 255;
  localparam int RAND_ITEMS = 480;
  localparam int CYCLE_CAP  = 400000;
  localparam int TAIL_WAIT  = 20;

  typedef struct packed {
    logic [7:0] off;
    logic [7:0] len;
    logic [7:0] nxt_char;
    logic       eos;
  } token_t;

  typedef logic [7:0] text_t[$];

  logic clk;
  logic rst;

  lzte_in_if  text_if();
  lzte_out_if token_if();

  lz77_token_encoder_top u_top (
    .clk   (clk),
    .rst   (rst),
    .text  (text_if),
    .token (token_if)
  );

  // Encoder state as the predictor sees it.
  logic [7:0] win_bytes [WIN];
  int         win_fill;
  bit         live_off [WIN];
  int         run_len;
  int         run_off;

  token_t expected_tokens[$];
  int     n_errs;
  int     n_cycles;
  bit     calm;
  text_t  txt;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic void clear_run();
    for (int k = 0; k < WIN; k++) live_off[k] = 1'b0;
    run_len = 0;
    run_off = 0;
  endfunction

  function automatic void clear_window();
    for (int k = 0; k < WIN; k++) win_bytes[k] = 8'h00;
    win_fill = 0;
    clear_run();
  endfunction

  // Greedy match tracking for one text byte; returns 1 when a token is emitted.
  function automatic bit encode_byte(input logic [7:0] b, input bit lst, output token_t tok);
    bit still_live [WIN];
    int hit_off;
    bit produced;
    produced = 1'b0;
    hit_off  = 0;
    tok      = '0;
    if (run_len == 0) begin
      for (int k = 0; k < WIN; k++) begin
        live_off[k] = (k < win_fill) && (win_bytes[k] == b);
        if (live_off[k]) hit_off = k + 1;
      end
      if (hit_off == 0) begin
        tok.nxt_char = b;
        tok.eos      = lst;
        produced     = 1'b1;
      end else begin
        run_len = 1;
        run_off = hit_off;
        if (lst) begin
          tok.off  = run_off[7:0];
          tok.len  = 8'd1;
          tok.eos  = 1'b1;
          produced = 1'b1;
        end
      end
    end else if (run_len >= MAX_RUN) begin
      // At the length cap the byte is taken as the next char without comparing.
      tok.off      = run_off[7:0];
      tok.len      = run_len[7:0];
      tok.nxt_char = b;
      tok.eos      = lst;
      produced     = 1'b1;
      clear_run();
    end else begin
      for (int k = 0; k < WIN; k++) begin
        still_live[k] = live_off[k] && (win_bytes[k] == b);
        if (still_live[k]) hit_off = k + 1;
      end
      if (hit_off == 0) begin
        tok.off      = run_off[7:0];
        tok.len      = run_len[7:0];
        tok.nxt_char = b;
        tok.eos      = lst;
        produced     = 1'b1;
        clear_run();
      end else begin
        for (int k = 0; k < WIN; k++) live_off[k] = still_live[k];
        run_len = run_len + 1;
        run_off = hit_off;
        if (lst) begin
          tok.off  = run_off[7:0];
          tok.len  = run_len[7:0];
          tok.eos  = 1'b1;
          produced = 1'b1;
        end
      end
    end
    if (lst) begin
      clear_window();
    end else begin
      for (int k = WIN - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = b;
      if (win_fill < WIN) win_fill = win_fill + 1;
    end
    return produced;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit lst);
    token_t tok;
    while (!calm && $urandom_range(99) < 6) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid     <= 1'b1;
    text_if.data_byte <= b;
    text_if.last_byte <= lst;
    do @(posedge clk); while (!text_if.ready);
    if (encode_byte(b, lst, tok)) expected_tokens.push_back(tok);
  endtask

  // Sends the text held in txt, flagging its final byte.
  task automatic send_text();
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic hold_until_drained();
    text_if.valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  task automatic make_text(input int n, input int alpha_n, input int noise_pct);
    logic [7:0] alpha[$];
    alpha = {};
    txt   = {};
    for (int i = 0; i < alpha_n; i++) alpha.push_back(8'($urandom_range(255)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) txt.push_back(8'($urandom_range(255)));
      else txt.push_back(alpha[$urandom_range(alpha_n - 1)]);
    end
  endtask

  task automatic test_literals();
    // The reset window holds zeros, which must not count as history.
    txt = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h3C, 8'hC3};
    send_text();
    txt = '{8'hFF};
    send_text();
  endtask

  task automatic test_matches();
    // Overlapping run, then alternating bytes where several offsets tie.
    txt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h11, 8'hAB, 8'h00, 8'hAB, 8'h00, 8'hAB,
            8'h00, 8'hAB, 8'h22, 8'h11};
    send_text();
    txt = '{8'h61, 8'h62, 8'h61, 8'h62};
    send_text();
    txt = '{8'h61, 8'h62, 8'h61, 8'h63};
    send_text();
    // A new text starts with an empty window, so this is a literal.
    txt = '{8'h61};
    send_text();
    txt = '{8'h40, 8'h40};
    send_text();
  endtask

  task automatic test_length_limit();
    calm = 1'b1;
    txt = {};
    repeat (258) txt.push_back(8'hC3);
    txt.push_back(8'h3C);
    send_text();
    // Here the byte after the capped run closes the text.
    txt = {};
    repeat (257) txt.push_back(8'h96);
    send_text();
    calm = 1'b0;
  endtask

  task automatic test_full_window();
    txt = {};
    for (int i = 0; i < WIN; i++) txt.push_back(8'(i));
    txt.push_back(8'h00);
    txt.push_back(8'h01);
    txt.push_back(8'hFF);
    send_text();
  endtask

  task automatic test_drain_pause();
    txt = '{8'h10, 8'h20, 8'h10, 8'h20, 8'h10};
    foreach (txt[i]) send_byte(txt[i], 1'b0);
    hold_until_drained();
    txt = '{8'h20, 8'h10, 8'h77};
    send_text();
    hold_until_drained();
  endtask

  task automatic test_random_texts();
    int sent;
    int pick;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      calm = (sent >= 150 && sent < 330);
      pick = $urandom_range(99);
      if (pick < 60) make_text($urandom_range(30, 1), $urandom_range(6, 1), 10);
      else if (pick < 82) make_text($urandom_range(120, 31), $urandom_range(16, 2), 5);
      else if (pick < 86) make_text($urandom_range(560, 256), $urandom_range(3, 1), 2);
      else make_text($urandom_range(20, 1), 1, 100);
      send_text();
      sent += txt.size();
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    token_if.ready <= calm || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_CAP) begin
      $display("lz77_token_encoder_top_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst && token_if.valid && token_if.ready) begin
      got.off      = token_if.match_offset;
      got.len      = token_if.match_length;
      got.nxt_char = token_if.next_char;
      got.eos      = token_if.end_of_stream;
      if (expected_tokens.size() == 0) begin
        n_errs++;
        if (n_errs <= 10)
          $display("unexpected token: off=%0d len=%0d char=%02h eos=%0b",
                   got.off, got.len, got.nxt_char, got.eos);
      end else begin
        want = expected_tokens.pop_front();
        if (got.off !== want.off || got.len !== want.len ||
            got.nxt_char !== want.nxt_char || got.eos !== want.eos) begin
          n_errs++;
          if (n_errs <= 10)
            $display("token mismatch: expected off=%0d len=%0d char=%02h eos=%0b,",
                     want.off, want.len, want.nxt_char, want.eos,
                     " got off=%0d len=%0d char=%02h eos=%0b",
                     got.off, got.len, got.nxt_char, got.eos);
        end
      end
    end
  end

  initial begin
    rst                = 1'b1;
    calm               = 1'b0;
    n_errs             = 0;
    n_cycles           = 0;
    text_if.valid      = 1'b0;
    text_if.data_byte  = 8'h00;
    text_if.last_byte  = 1'b0;
    token_if.ready     = 1'b0;
    clear_window();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_literals();
    test_matches();
    test_length_limit();
    test_full_window();
    test_drain_pause();
    test_random_texts();

    text_if.valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_errs == 0 && expected_tokens.size() == 0) begin
      $display("lz77_token_encoder_top_test OK");
    end else begin
      $display("lz77_token_encoder_top_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
